// ----- hdl/bbc_pkg.sv -----
// Shared types and constants for the bright blob centroid block.
package bbc_pkg;

  localparam int AREA_W = 25;
  localparam int SUM_W  = 36;
  localparam int SIZE_W = 13;
  localparam int THR_W  = 8;
  localparam int RES_W  = 16;
  localparam int DEN_W  = SIZE_W + AREA_W;
  localparam int PROD_W = 22;

  localparam logic [PROD_W-1:0] LUMA_R_COEF = PROD_W'(4899);
  localparam logic [PROD_W-1:0] LUMA_G_COEF = PROD_W'(9617);
  localparam logic [PROD_W-1:0] LUMA_B_COEF = PROD_W'(1868);
  localparam logic [PROD_W:0]   LUMA_ROUND  = (PROD_W+1)'(8192);

  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_WIDTH      = 2'd1;
  localparam logic [1:0] REG_HEIGHT     = 2'd2;
  localparam logic [1:0] REG_AREA_FLOOR = 2'd3;

  localparam logic [THR_W-1:0]  RST_THRESHOLD  = THR_W'(200);
  localparam logic [SIZE_W-1:0] RST_WIDTH      = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RST_HEIGHT     = SIZE_W'(480);
  localparam logic [AREA_W-1:0] RST_AREA_FLOOR = AREA_W'(307);

  typedef struct packed {
    logic load;
    logic diff;
    logic check;
    logic step;
    logic fin;
    logic axis;
    logic out_load;
  } bbc_cmd_t;

  typedef struct packed {
    logic snap_done;
    logic out_free;
  } bbc_sts_t;

endpackage

// ----- hdl/bright_blob_centroid.sv -----
// Top level of the bright blob centroid block.
//
// Input stream: one BGR pixel per beat in raster order, in_tlast on the last
// pixel of each line, in_tuser on the last pixel of the frame. Pixels are taken
// one per cycle while in_tready is high.
// Result stream: one beat per frame, out_tuser = detected, out_tdata carries the
// Q1.FRACTION_BITS centroid on each axis and the lit pixel count.
// Frame end: after the last pixel is taken, in_tready drops while the pixel
// pipeline drains and the shared restoring divider normalises both axes in
// turn, one quotient bit per cycle. The result then enters the output register
// once that register is free, and in_tready returns.
// A result left waiting holds in the output register; the next frame streams
// in meanwhile and only its own frame end waits for that register to empty.
// Reset (synchronous, rst_n low) clears the counters, sums and output valid
// and loads the register defaults: threshold 200, size 640x480, area floor 307.
// Registers on the APB port: 0x0 threshold, 0x4 width, 0x8 height, 0xC area floor.
module bright_blob_centroid #(
  parameter int COORD_BITS    = 12,
  parameter int FRACTION_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic        in_tlast,   // end_of_line
  input  logic        in_tuser,   // end_of_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // centroid_x[15:0], centroid_y[31:16], lit_count[56:32]
  output logic        out_tuser,  // detected
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bbc_pkg::*;

  logic [THR_W-1:0]  thr_r;
  logic [SIZE_W-1:0] width_r, height_r;
  logic [AREA_W-1:0] area_floor_r;

  logic              accept, cfg_wr;
  bbc_cmd_t          cmd;
  bbc_sts_t          sts;
  logic              snap_done;
  logic [AREA_W-1:0] area_snap;
  logic [SUM_W-1:0]  x_snap, y_snap;
  logic signed [RES_W-1:0] cx, cy;
  logic              det;

  logic              out_valid_r;
  logic              out_det_r;
  logic signed [RES_W-1:0] out_cx_r, out_cy_r;
  logic [AREA_W-1:0] out_cnt_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= RST_THRESHOLD;
      width_r      <= RST_WIDTH;
      height_r     <= RST_HEIGHT;
      area_floor_r <= RST_AREA_FLOOR;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_THRESHOLD:  thr_r        <= cfg_pwdata[THR_W-1:0];
        REG_WIDTH:      width_r      <= cfg_pwdata[SIZE_W-1:0];
        REG_HEIGHT:     height_r     <= cfg_pwdata[SIZE_W-1:0];
        REG_AREA_FLOOR: area_floor_r <= cfg_pwdata[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_THRESHOLD:  cfg_prdata = 32'(thr_r);
      REG_WIDTH:      cfg_prdata = 32'(width_r);
      REG_HEIGHT:     cfg_prdata = 32'(height_r);
      REG_AREA_FLOOR: cfg_prdata = 32'(area_floor_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  bbc_pixel #(
    .COORD_BITS (COORD_BITS)
  ) u_pixel (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .blue         (in_tdata[7:0]),
    .green        (in_tdata[15:8]),
    .red          (in_tdata[23:16]),
    .end_of_line  (in_tlast),
    .end_of_frame (in_tuser),
    .threshold    (thr_r),
    .snap_done    (snap_done),
    .area_snap    (area_snap),
    .x_snap       (x_snap),
    .y_snap       (y_snap)
  );

  assign sts.snap_done = snap_done;
  assign sts.out_free  = !out_valid_r || out_tready;

  bbc_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .eof_accept (accept && in_tuser),
    .sts        (sts),
    .in_ready   (in_tready),
    .cmd        (cmd)
  );

  bbc_norm #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_norm (
    .clk          (clk),
    .cmd          (cmd),
    .x_sum        (x_snap),
    .y_sum        (y_snap),
    .count        (area_snap),
    .frame_width  (width_r),
    .frame_height (height_r),
    .centroid_x   (cx),
    .centroid_y   (cy)
  );

  assign det = (area_snap != '0) && (area_snap >= area_floor_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_det_r <= det;
      out_cx_r  <= det ? cx : '0;
      out_cy_r  <= det ? cy : '0;
      out_cnt_r <= area_snap;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_det_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_cy_r, out_cx_r};

endmodule

// ----- hdl/bbc_pixel.sv -----
// Pixel pipeline: luma, threshold, lit-pixel moment accumulators and frame snapshot.
module bbc_pixel #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [7:0]                  blue,
  input  logic [7:0]                  green,
  input  logic [7:0]                  red,
  input  logic                        end_of_line,
  input  logic                        end_of_frame,
  input  logic [bbc_pkg::THR_W-1:0]   threshold,
  output logic                        snap_done,
  output logic [bbc_pkg::AREA_W-1:0]  area_snap,
  output logic [bbc_pkg::SUM_W-1:0]   x_snap,
  output logic [bbc_pkg::SUM_W-1:0]   y_snap
);
  import bbc_pkg::*;

  logic [COORD_BITS-1:0] column_r, row_r;

  logic                  v0_r, eof0_r;
  logic [PROD_W-1:0]     pr_r, pg_r, pb_r;
  logic [COORD_BITS-1:0] col0_r, row0_r;

  logic                  v1_r, eof1_r, lit1_r;
  logic [COORD_BITS-1:0] col1_r, row1_r;

  logic [AREA_W-1:0]     area_r, area_nxt;
  logic [SUM_W-1:0]      xs_r, xs_nxt, ys_r, ys_nxt;
  logic [AREA_W-1:0]     area_snap_r;
  logic [SUM_W-1:0]      x_snap_r, y_snap_r;
  logic                  snap_done_r;

  logic [PROD_W:0]       luma_sum;
  logic [7:0]            luma;
  logic [AREA_W:0]       area_inc;
  logic [SUM_W:0]        xs_inc, ys_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
    end else if (accept) begin
      if (end_of_frame) begin
        column_r <= '0;
        row_r    <= '0;
      end else if (end_of_line) begin
        column_r <= '0;
        row_r    <= row_r + 1'b1;
      end else begin
        column_r <= column_r + 1'b1;
      end
    end
  end

  // stage 0: weighted components
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pr_r   <= PROD_W'(red)   * LUMA_R_COEF;
      pg_r   <= PROD_W'(green) * LUMA_G_COEF;
      pb_r   <= PROD_W'(blue)  * LUMA_B_COEF;
      col0_r <= column_r;
      row0_r <= row_r;
      eof0_r <= end_of_frame;
    end
  end

  // stage 1: luma and threshold
  assign luma_sum = (PROD_W+1)'(pr_r) + (PROD_W+1)'(pg_r) + (PROD_W+1)'(pb_r) + LUMA_ROUND;
  assign luma     = luma_sum[21:14];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v0_r) begin
      lit1_r <= luma > threshold;
      col1_r <= col0_r;
      row1_r <= row0_r;
      eof1_r <= eof0_r;
    end
  end

  // stage 2: saturating accumulators
  assign area_inc = (AREA_W+1)'(area_r) + (AREA_W+1)'(1);
  assign xs_inc   = (SUM_W+1)'(xs_r) + (SUM_W+1)'(col1_r);
  assign ys_inc   = (SUM_W+1)'(ys_r) + (SUM_W+1)'(row1_r);

  always_comb begin
    area_nxt = area_r;
    xs_nxt   = xs_r;
    ys_nxt   = ys_r;
    if (lit1_r) begin
      area_nxt = area_inc[AREA_W] ? '1 : area_inc[AREA_W-1:0];
      xs_nxt   = xs_inc[SUM_W]    ? '1 : xs_inc[SUM_W-1:0];
      ys_nxt   = ys_inc[SUM_W]    ? '1 : ys_inc[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r      <= '0;
      xs_r        <= '0;
      ys_r        <= '0;
      snap_done_r <= 1'b0;
    end else begin
      snap_done_r <= v1_r && eof1_r;
      if (v1_r) begin
        if (eof1_r) begin
          area_r <= '0;
          xs_r   <= '0;
          ys_r   <= '0;
        end else begin
          area_r <= area_nxt;
          xs_r   <= xs_nxt;
          ys_r   <= ys_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && eof1_r) begin
      area_snap_r <= area_nxt;
      x_snap_r    <= xs_nxt;
      y_snap_r    <= ys_nxt;
    end
  end

  assign snap_done = snap_done_r;
  assign area_snap = area_snap_r;
  assign x_snap    = x_snap_r;
  assign y_snap    = y_snap_r;

endmodule

// ----- hdl/bbc_norm.sv -----
// Centroid normalisation datapath: product, offset, restoring divide and rounding.
module bbc_norm #(
  parameter int FRACTION_BITS = 14
) (
  input  logic                              clk,
  input  bbc_pkg::bbc_cmd_t                 cmd,
  input  logic [bbc_pkg::SUM_W-1:0]         x_sum,
  input  logic [bbc_pkg::SUM_W-1:0]         y_sum,
  input  logic [bbc_pkg::AREA_W-1:0]        count,
  input  logic [bbc_pkg::SIZE_W-1:0]        frame_width,
  input  logic [bbc_pkg::SIZE_W-1:0]        frame_height,
  output logic signed [bbc_pkg::RES_W-1:0]  centroid_x,
  output logic signed [bbc_pkg::RES_W-1:0]  centroid_y
);
  import bbc_pkg::*;

  localparam int QW = FRACTION_BITS + 1;
  localparam logic [QW-1:0] ONE = QW'(1) << FRACTION_BITS;

  logic [DEN_W-1:0]   den_r, mag_r;
  logic [SUM_W:0]     twice_r;
  logic               neg_r, zero_r, sat_r;
  logic [QW-1:0]      quo_r;
  logic signed [RES_W-1:0] cx_r, cy_r;

  logic [SUM_W-1:0]   sum_sel;
  logic [SIZE_W-1:0]  size_sel;
  logic [DEN_W-1:0]   twice_ext;
  logic [DEN_W:0]     rem2, den_ext;
  logic               rem_ge;
  logic [QW:0]        q_inc;
  logic [QW-1:0]      q_mag;
  logic [31:0]        val32;

  assign sum_sel   = cmd.axis ? y_sum : x_sum;
  assign size_sel  = cmd.axis ? frame_height : frame_width;
  assign twice_ext = DEN_W'(twice_r);
  assign rem2      = {mag_r, 1'b0};
  assign den_ext   = {1'b0, den_r};
  assign rem_ge    = rem2 >= den_ext;

  assign q_inc = (QW+1)'(quo_r) + (QW+1)'(1);
  assign q_mag = sat_r ? ONE : q_inc[QW:1];

  always_comb begin
    val32 = 32'(q_mag);
    if (neg_r) begin
      val32 = ~val32 + 32'd1;
    end
    if (zero_r) begin
      val32 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_r   <= DEN_W'(size_sel) * DEN_W'(count);
      twice_r <= {sum_sel, 1'b0};
      zero_r  <= size_sel == '0;
    end
    if (cmd.diff) begin
      neg_r <= twice_ext < den_r;
      mag_r <= (twice_ext < den_r) ? den_r - twice_ext : twice_ext - den_r;
    end
    if (cmd.check) begin
      sat_r <= mag_r >= den_r;
      quo_r <= '0;
    end
    if (cmd.step && !sat_r) begin
      if (rem_ge) begin
        mag_r <= DEN_W'(rem2 - den_ext);
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        mag_r <= rem2[DEN_W-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
    end
    if (cmd.fin) begin
      if (cmd.axis) begin
        cy_r <= val32[RES_W-1:0];
      end else begin
        cx_r <= val32[RES_W-1:0];
      end
    end
  end

  assign centroid_x = cx_r;
  assign centroid_y = cy_r;

endmodule

// ----- hdl/bbc_ctrl.sv -----
// Controller: input flow control and frame-end normalisation sequence.
module bbc_ctrl #(
  parameter int FRACTION_BITS = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              eof_accept,
  input  bbc_pkg::bbc_sts_t sts,
  output logic              in_ready,
  output bbc_pkg::bbc_cmd_t cmd
);
  import bbc_pkg::*;

  localparam int CW = $clog2(FRACTION_BITS + 2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WAIT  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_DIFF  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    case (state_r)
      S_IDLE: begin
        if (eof_accept) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts.snap_done) begin
          axis_nxt  = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD:  state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_CHECK;
      S_CHECK: begin
        cnt_nxt   = CW'(FRACTION_BITS);
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        if (axis_r) begin
          state_nxt = S_OUT;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign in_ready     = state_r == S_IDLE;
  assign cmd.load     = state_r == S_LOAD;
  assign cmd.diff     = state_r == S_DIFF;
  assign cmd.check    = state_r == S_CHECK;
  assign cmd.step     = state_r == S_STEP;
  assign cmd.fin      = state_r == S_FIN;
  assign cmd.axis     = axis_r;
  assign cmd.out_load = (state_r == S_OUT) && sts.out_free;

endmodule

// ----- hdl/bbc_checker.sv -----
// Port-level checks for the bright blob centroid block, with its bind.
module bbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat dropped or changed while stalled");

  a_no_det_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:0] == 32'd0)
    else $error("centroid not zero on a beat without detection");

  a_det_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[56:32] != 25'd0)
    else $error("detection reported with no lit pixels");

  a_rose_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a frame-end stall");

endmodule

bind bright_blob_centroid bbc_checker u_bbc_checker (.*);
